// ===== rtl/tcp_connection_fsm_top_assert.svh =====
// Assertion macros shared by the connection machine's RTL files.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef TCP_CONNECTION_FSM_TOP_ASSERT_SVH
`define TCP_CONNECTION_FSM_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPFSM_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPFSM_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/tcpfsm_pkg.sv =====
package tcpfsm_pkg;

	localparam int LEN_W       = 10;
	localparam int MAX_PAYLOAD = 536;
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

	localparam logic [7:0] F_FIN = 8'h01;
	localparam logic [7:0] F_SYN = 8'h02;
	localparam logic [7:0] F_ACK = 8'h10;

	localparam logic        RST_ACTIVE_OPEN = 1'b0;
	localparam logic [31:0] RST_INITIAL_SEQ = 32'd1;
	localparam logic [15:0] RST_ADV_WINDOW  = 16'd3072;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_CLOSE = 2'd2,
		OP_SEG   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_ACTIVE_OPEN = 2'd0,
		CFG_INITIAL_SEQ = 2'd1,
		CFG_ADV_WINDOW  = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_LISTEN     = 4'd0,
		PH_SYN_SENT   = 4'd1,
		PH_SYN_RCVD   = 4'd2,
		PH_ESTAB      = 4'd3,
		PH_DATA_WAIT  = 4'd4,
		PH_LAST_ACK   = 4'd5,
		PH_FIN_WAIT_1 = 4'd6,
		PH_FIN_WAIT_2 = 4'd7,
		PH_CLOSING    = 4'd8,
		PH_CLOSED     = 4'd9,
		PH_REFUSED    = 4'd10
	} phase_t;

	typedef struct packed {
		logic        active_open;
		logic [31:0] initial_seq;
		logic [15:0] adv_window;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [7:0]       seg_flags;
		logic [31:0]      seg_seq;
		logic [31:0]      seg_ack;
		logic [LEN_W-1:0] seg_len;
		logic             header_ok;
		logic [LEN_W-1:0] app_len;
	} item_t;

	typedef struct packed {
		logic             send_segment;
		logic [7:0]       out_flags;
		logic [31:0]      out_seq;
		logic [31:0]      out_ack;
		logic [15:0]      out_win;
		logic [LEN_W-1:0] out_payload_len;
		logic [LEN_W-1:0] deliver_len;
		logic             app_unblock;
		logic             fin_received;
		logic             conn_done;
		logic             refused;
		logic             last_result;
	} res_t;

	// Results of one event: one or two entries for the result queue.
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} core_res_t;

	// Status of the result queue towards the top level.
	typedef struct packed {
		logic head_valid;
		logic has_room;
	} outq_stat_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] lim;
		lim = LEN_W'(MAX_PAYLOAD);
		return (v > lim) ? lim : v;
	endfunction

endpackage

// ===== rtl/tcpfsm_cfg.sv =====
module tcpfsm_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	output tcpfsm_pkg::cfg_t   cfg
);
	import tcpfsm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_open <= RST_ACTIVE_OPEN;
			cfg_q.initial_seq <= RST_INITIAL_SEQ;
			cfg_q.adv_window  <= RST_ADV_WINDOW;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ACTIVE_OPEN: cfg_q.active_open <= cfg_wdata[0];
				CFG_INITIAL_SEQ: cfg_q.initial_seq <= cfg_wdata;
				CFG_ADV_WINDOW:  cfg_q.adv_window  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tcpfsm_core.sv =====
`include "tcp_connection_fsm_top_assert.svh"

module tcpfsm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  tcpfsm_pkg::item_t     item,
	input  tcpfsm_pkg::cfg_t      cfg,
	output tcpfsm_pkg::core_res_t res
);
	import tcpfsm_pkg::*;

	phase_t           phase_q, phase_d;
	logic [31:0]      peer_seq_q, peer_ack_q;
	logic [LEN_W-1:0] peer_len_q;
	logic             store;
	logic             seq_bump;
	logic             bad;
	logic             segok;
	logic [LEN_W-1:0] slen, alen;
	logic [31:0]      sseq_p1, sack_p1, sseq_plen, peer_sum;
	res_t             r0, r1;

	function automatic res_t mk_seg(input logic [7:0] flags, input logic [31:0] seq,
			input logic [31:0] ack, input logic [LEN_W-1:0] plen, input logic [15:0] win);
		res_t r;
		r                 = '0;
		r.send_segment    = 1'b1;
		r.out_flags       = flags;
		r.out_seq         = seq;
		r.out_ack         = ack;
		r.out_win         = win;
		r.out_payload_len = plen;
		return r;
	endfunction

	assign slen      = clamp_len(item.seg_len);
	assign alen      = clamp_len(item.app_len);
	assign segok     = (item.opcode == OP_SEG) && item.header_ok;
	assign sseq_p1   = item.seg_seq + 32'd1;
	assign sack_p1   = item.seg_ack + 32'd1;
	assign sseq_plen = item.seg_seq + 32'(slen);
	assign peer_sum  = peer_seq_q + 32'(peer_len_q);

	always_comb begin
		phase_d  = phase_q;
		store    = 1'b0;
		seq_bump = 1'b0;
		bad      = 1'b0;
		r0       = '0;
		r1       = '0;
		res.two  = 1'b0;
		unique case (phase_q)
			PH_LISTEN: begin
				if (item.opcode == OP_START) begin
					if (cfg.active_open) begin
						r0      = mk_seg(F_SYN, cfg.initial_seq, 32'd0, '0, cfg.adv_window);
						phase_d = PH_SYN_SENT;
					end
				end else if (segok && !cfg.active_open && item.seg_flags == F_SYN) begin
					store   = 1'b1;
					r0      = mk_seg(F_SYN | F_ACK, cfg.initial_seq, sseq_p1, '0,
						cfg.adv_window);
					phase_d = PH_SYN_RCVD;
				end else begin
					bad = 1'b1;
				end
			end
			PH_SYN_SENT: begin
				if (segok && item.seg_flags == (F_SYN | F_ACK)) begin
					store          = 1'b1;
					seq_bump       = 1'b1;
					r0             = mk_seg(F_ACK, item.seg_ack, sseq_p1, '0, cfg.adv_window);
					r0.app_unblock = 1'b1;
					phase_d        = PH_ESTAB;
				end else begin
					bad = 1'b1;
				end
			end
			PH_SYN_RCVD: begin
				if (segok && item.seg_flags == F_ACK) begin
					store          = 1'b1;
					r0.app_unblock = 1'b1;
					phase_d        = PH_ESTAB;
				end else begin
					bad = 1'b1;
				end
			end
			PH_ESTAB: begin
				if (item.opcode == OP_DATA) begin
					r0      = mk_seg(F_ACK, peer_ack_q, peer_sum, alen, cfg.adv_window);
					phase_d = PH_DATA_WAIT;
				end else if (item.opcode == OP_CLOSE) begin
					r0      = mk_seg(F_FIN | F_ACK, peer_ack_q, peer_sum, '0, cfg.adv_window);
					phase_d = PH_FIN_WAIT_1;
				end else if (segok) begin
					store = 1'b1;
					if (item.seg_flags == (F_FIN | F_ACK)) begin
						r0              = mk_seg(F_ACK, item.seg_ack, sseq_p1, '0,
							cfg.adv_window);
						r0.fin_received = 1'b1;
						r1              = mk_seg(F_FIN | F_ACK, item.seg_ack, sseq_p1, '0,
							cfg.adv_window);
						res.two         = 1'b1;
						phase_d         = PH_LAST_ACK;
					end else begin
						r0             = mk_seg(F_ACK, item.seg_ack, sseq_plen, '0,
							cfg.adv_window);
						r0.deliver_len = slen;
					end
				end else begin
					bad = 1'b1;
				end
			end
			PH_DATA_WAIT: begin
				if (segok) begin
					store   = 1'b1;
					phase_d = PH_ESTAB;
				end else begin
					bad = 1'b1;
				end
			end
			PH_LAST_ACK, PH_CLOSING: begin
				if (segok && item.seg_flags == F_ACK) begin
					store        = 1'b1;
					r0.conn_done = 1'b1;
					phase_d      = PH_CLOSED;
				end else begin
					bad = 1'b1;
				end
			end
			PH_FIN_WAIT_1: begin
				if (segok && item.seg_flags == (F_FIN | F_ACK)) begin
					store           = 1'b1;
					r0              = mk_seg(F_ACK, sack_p1, sseq_p1, '0, cfg.adv_window);
					r0.fin_received = 1'b1;
					phase_d         = PH_CLOSING;
				end else if (segok && item.seg_flags == F_ACK) begin
					store   = 1'b1;
					phase_d = PH_FIN_WAIT_2;
				end else begin
					bad = 1'b1;
				end
			end
			PH_FIN_WAIT_2: begin
				if (segok && item.seg_flags == (F_FIN | F_ACK)) begin
					store           = 1'b1;
					r0              = mk_seg(F_ACK, item.seg_ack, sseq_p1, '0, cfg.adv_window);
					r0.fin_received = 1'b1;
					r0.conn_done    = 1'b1;
					phase_d         = PH_CLOSED;
				end else begin
					bad = 1'b1;
				end
			end
			PH_CLOSED: begin
				r0.refused = 1'b1;
			end
			default: begin
				r0.refused = 1'b1;
				phase_d    = PH_REFUSED;
			end
		endcase

		// An unexpected event discards everything above and aborts.
		if (bad) begin
			r0         = '0;
			r1         = '0;
			r0.refused = 1'b1;
			res.two    = 1'b0;
			store      = 1'b0;
			phase_d    = PH_REFUSED;
		end

		r0.last_result = !res.two;
		r1.last_result = 1'b1;
		res.r0         = r0;
		res.r1         = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LISTEN;
			peer_seq_q <= '0;
			peer_ack_q <= '0;
			peer_len_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (store) begin
				peer_seq_q <= seq_bump ? sseq_p1 : item.seg_seq;
				peer_ack_q <= item.seg_ack;
				peer_len_q <= slen;
			end
		end
	end

	`TCPFSM_AST_NXT(a_refused_sticky, phase_q == PH_REFUSED, phase_q == PH_REFUSED,
		"refused phase left without reset")
	`TCPFSM_AST_NXT(a_closed_sticky, phase_q == PH_CLOSED, phase_q == PH_CLOSED,
		"closed phase left without reset")
	`TCPFSM_AST_IMP(a_two_only_estab, fire && res.two,
		phase_q == PH_ESTAB && item.opcode == OP_SEG, "two results outside established")

endmodule

// ===== rtl/tcpfsm_outq.sv =====
`include "tcp_connection_fsm_top_assert.svh"

module tcpfsm_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tcpfsm_pkg::core_res_t  res,
	input  logic                   pop,
	output tcpfsm_pkg::res_t       head,
	output tcpfsm_pkg::outq_stat_t stat
);
	import tcpfsm_pkg::*;

	localparam logic [OUTQ_CNT_W-1:0] ROOM_MAX = OUTQ_CNT_W'(OUTQ_DEPTH - 2);

	res_t                  entry_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [OUTQ_CNT_W-1:0] count_q, push_n;
	logic                  do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign push_n    = push ? (res.two ? OUTQ_CNT_W'(2) : OUTQ_CNT_W'(1)) : '0;
	assign wr_ptr_p1 = wr_ptr_q + OUTQ_PTR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(push_n);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
			end
			count_q <= count_q + push_n - OUTQ_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= res.r0;
			if (res.two) begin
				entry_q[wr_ptr_p1] <= res.r1;
			end
		end
	end

	assign head            = entry_q[rd_ptr_q];
	assign stat.head_valid = (count_q != '0);
	assign stat.has_room   = (count_q <= ROOM_MAX);

	`TCPFSM_AST_IMP(a_count_bound, 1'b1, count_q <= OUTQ_CNT_W'(OUTQ_DEPTH),
		"result queue overfilled")
	`TCPFSM_AST_IMP(a_push_room, push, count_q <= ROOM_MAX,
		"event taken without room for two results")
	`TCPFSM_AST_NXT(a_push_two, push && res.two && !do_pop,
		count_q == $past(count_q) + OUTQ_CNT_W'(2), "double push lost an entry")

endmodule

// ===== rtl/tcp_connection_fsm_top.sv =====
// Simplified stop-and-wait connection state machine. Each input transaction is one event
// (start, application data, application close or received segment) and produces one or two
// result transactions; the last of them carries last_result. The block takes one event per
// clock cycle while the input is not stalled: an event is captured in an input register,
// decided by the phase logic and written into a four-entry result queue once the queue
// has room. The input side stalls only while an event waits in the input
// register and the result queue has fewer than two free entries, which is what sets the rate
// when the output side stalls; with the output side taking a result every cycle, events of
// one result each flow at one per cycle. Configuration registers (active_open at index 0,
// initial_seq at 1, adv_window at 2) may be written only while no event is in flight.
`include "tcp_connection_fsm_top_assert.svh"

module tcp_connection_fsm_top (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [31:0]                  cfg_wdata,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic [7:0]                   seg_flags,
	input  logic [31:0]                  seg_seq,
	input  logic [31:0]                  seg_ack,
	input  logic [tcpfsm_pkg::LEN_W-1:0] seg_len,
	input  logic                         header_ok,
	input  logic [tcpfsm_pkg::LEN_W-1:0] app_len,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         send_segment,
	output logic [7:0]                   out_flags,
	output logic [31:0]                  out_seq,
	output logic [31:0]                  out_ack,
	output logic [15:0]                  out_win,
	output logic [tcpfsm_pkg::LEN_W-1:0] out_payload_len,
	output logic [tcpfsm_pkg::LEN_W-1:0] deliver_len,
	output logic                         app_unblock,
	output logic                         fin_received,
	output logic                         conn_done,
	output logic                         refused,
	output logic                         last_result
);
	import tcpfsm_pkg::*;

	cfg_t       cfg;
	item_t      item_s1;
	logic       valid_s1;
	logic       accept, fire;
	core_res_t  core_res;
	res_t       head;
	outq_stat_t qstat;

	// The input register is free when empty or when its event is decided this cycle.
	assign fire     = valid_s1 && qstat.has_room;
	assign in_stall = valid_s1 && !qstat.has_room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode    <= opcode;
			item_s1.seg_flags <= seg_flags;
			item_s1.seg_seq   <= seg_seq;
			item_s1.seg_ack   <= seg_ack;
			item_s1.seg_len   <= seg_len;
			item_s1.header_ok <= header_ok;
			item_s1.app_len   <= app_len;
		end
	end

	tcpfsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tcpfsm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	tcpfsm_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.res    (core_res),
		.pop    (!out_stall),
		.head   (head),
		.stat   (qstat)
	);

	assign out_valid       = qstat.head_valid;
	assign send_segment    = head.send_segment;
	assign out_flags       = head.out_flags;
	assign out_seq         = head.out_seq;
	assign out_ack         = head.out_ack;
	assign out_win         = head.out_win;
	assign out_payload_len = head.out_payload_len;
	assign deliver_len     = head.deliver_len;
	assign app_unblock     = head.app_unblock;
	assign fin_received    = head.fin_received;
	assign conn_done       = head.conn_done;
	assign refused         = head.refused;
	assign last_result     = head.last_result;

	// An event waiting in the input register is decided no later than the cycle the queue has room.
	`TCPFSM_AST_IMP(a_fire_when_room, valid_s1 && qstat.has_room, !in_stall,
		"input stalled although the result queue has room")
	`TCPFSM_AST_NXT(a_accept_fills, accept, valid_s1, "accepted event not held in stage one")

endmodule

// ===== test/tb_tcp_connection_fsm_top.sv =====
`timescale 1ns / 100ps

module tb_tcp_connection_fsm_top;
	import tcpfsm_pkg::*;

	localparam logic [7:0] FL_SYNACK = F_SYN | F_ACK;
	localparam logic [7:0] FL_FINACK = F_FIN | F_ACK;

	// Length of the long receiver hold-off, in clock cycles.
	localparam int HOLD_CYCLES = 300;

	// Item counts at which the random part moves to its next idling pattern, and where it ends.
	localparam int STAGE1_AT   = 500;
	localparam int STAGE2_AT   = 1000;
	localparam int RANDOM_UPTO = 1500;
	localparam int NOISE_ITEMS = 100;

	typedef enum int {
		END_PASSIVE,
		END_ACTIVE,
		END_SIMULT,
		END_ABORT
	} ending_t;

	// Scoreboard: keeps its own copy of the connection state and the configuration, works
	// out the results of every accepted event and checks the results in arrival order.
	class conn_scoreboard;
		logic             active_open;
		logic [31:0]      initial_seq;
		logic [15:0]      adv_window;
		phase_t           phase;
		logic [31:0]      peer_seq;
		logic [31:0]      peer_ack;
		logic [LEN_W-1:0] peer_len;
		res_t             awaited_q[$];
		int               errors;
		int               n_events;
		int               n_results;
		int               n_refused;
		int               n_delivered;
		int               n_fin;

		function new();
			active_open = RST_ACTIVE_OPEN;
			initial_seq = RST_INITIAL_SEQ;
			adv_window  = RST_ADV_WINDOW;
			phase       = PH_LISTEN;
			peer_seq    = '0;
			peer_ack    = '0;
			peer_len    = '0;
			errors      = 0;
			n_events    = 0;
			n_results   = 0;
			n_refused   = 0;
			n_delivered = 0;
			n_fin       = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] value);
			case (idx)
				CFG_ACTIVE_OPEN: active_open = value[0];
				CFG_INITIAL_SEQ: initial_seq = value;
				CFG_ADV_WINDOW:  adv_window  = value[15:0];
				default: ;
			endcase
		endfunction

		function logic [LEN_W-1:0] saturate(logic [LEN_W-1:0] v);
			return (v > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : v;
		endfunction

		function void take_peer(item_t ev);
			peer_seq = ev.seg_seq;
			peer_ack = ev.seg_ack;
			peer_len = saturate(ev.seg_len);
		endfunction

		function res_t segment(logic [7:0] fl, logic [31:0] sq, logic [31:0] ak,
				logic [LEN_W-1:0] plen);
			res_t r;
			r                 = '0;
			r.send_segment    = 1'b1;
			r.out_flags       = fl;
			r.out_seq         = sq;
			r.out_ack         = ak;
			r.out_win         = adv_window;
			r.out_payload_len = plen;
			return r;
		endfunction

		function void note_event(item_t ev);
			res_t r0;
			res_t r1;
			logic two;
			logic bad;
			logic segok;
			r0    = '0;
			r1    = '0;
			two   = 1'b0;
			bad   = 1'b0;
			segok = (ev.opcode == OP_SEG) && ev.header_ok;
			n_events++;
			case (phase)
				PH_LISTEN: begin
					if (ev.opcode == OP_START) begin
						if (active_open) begin
							r0    = segment(F_SYN, initial_seq, '0, '0);
							phase = PH_SYN_SENT;
						end
					end else if (segok && !active_open && ev.seg_flags == F_SYN) begin
						take_peer(ev);
						r0    = segment(FL_SYNACK, initial_seq, peer_seq + 1, '0);
						phase = PH_SYN_RCVD;
					end else begin
						bad = 1'b1;
					end
				end
				PH_SYN_SENT: begin
					if (segok && ev.seg_flags == FL_SYNACK) begin
						take_peer(ev);
						r0             = segment(F_ACK, peer_ack, peer_seq + 1, '0);
						r0.app_unblock = 1'b1;
						peer_seq       = peer_seq + 1;
						phase          = PH_ESTAB;
					end else begin
						bad = 1'b1;
					end
				end
				PH_SYN_RCVD: begin
					if (segok && ev.seg_flags == F_ACK) begin
						take_peer(ev);
						r0.app_unblock = 1'b1;
						phase          = PH_ESTAB;
					end else begin
						bad = 1'b1;
					end
				end
				PH_ESTAB: begin
					if (ev.opcode == OP_DATA) begin
						r0    = segment(F_ACK, peer_ack, peer_seq + peer_len,
							saturate(ev.app_len));
						phase = PH_DATA_WAIT;
					end else if (ev.opcode == OP_CLOSE) begin
						r0    = segment(FL_FINACK, peer_ack, peer_seq + peer_len, '0);
						phase = PH_FIN_WAIT_1;
					end else if (segok) begin
						take_peer(ev);
						if (ev.seg_flags == FL_FINACK) begin
							// Peer closes first: acknowledge its FIN, then send our own.
							r0              = segment(F_ACK, peer_ack, peer_seq + 1, '0);
							r0.fin_received = 1'b1;
							r1              = segment(FL_FINACK, peer_ack, peer_seq + 1, '0);
							two             = 1'b1;
							phase           = PH_LAST_ACK;
						end else begin
							r0             = segment(F_ACK, peer_ack, peer_seq + peer_len, '0);
							r0.deliver_len = peer_len;
						end
					end else begin
						bad = 1'b1;
					end
				end
				PH_DATA_WAIT: begin
					// The reply to our data is kept whatever its flags say.
					if (segok) begin
						take_peer(ev);
						phase = PH_ESTAB;
					end else begin
						bad = 1'b1;
					end
				end
				PH_LAST_ACK, PH_CLOSING: begin
					if (segok && ev.seg_flags == F_ACK) begin
						take_peer(ev);
						r0.conn_done = 1'b1;
						phase        = PH_CLOSED;
					end else begin
						bad = 1'b1;
					end
				end
				PH_FIN_WAIT_1: begin
					if (segok && ev.seg_flags == FL_FINACK) begin
						take_peer(ev);
						r0              = segment(F_ACK, peer_ack + 1, peer_seq + 1, '0);
						r0.fin_received = 1'b1;
						phase           = PH_CLOSING;
					end else if (segok && ev.seg_flags == F_ACK) begin
						take_peer(ev);
						phase = PH_FIN_WAIT_2;
					end else begin
						bad = 1'b1;
					end
				end
				PH_FIN_WAIT_2: begin
					if (segok && ev.seg_flags == FL_FINACK) begin
						take_peer(ev);
						r0              = segment(F_ACK, peer_ack, peer_seq + 1, '0);
						r0.fin_received = 1'b1;
						r0.conn_done    = 1'b1;
						phase           = PH_CLOSED;
					end else begin
						bad = 1'b1;
					end
				end
				PH_CLOSED: begin
					r0.refused = 1'b1;
				end
				default: begin
					r0.refused = 1'b1;
					phase      = PH_REFUSED;
				end
			endcase
			if (bad) begin
				r0         = '0;
				r0.refused = 1'b1;
				two        = 1'b0;
				phase      = PH_REFUSED;
			end
			r0.last_result = !two;
			awaited_q.push_back(r0);
			if (two) begin
				r1.last_result = 1'b1;
				awaited_q.push_back(r1);
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited_q.size() == 0) begin
				$error("result arrived with none awaited");
				errors++;
				return;
			end
			want = awaited_q.pop_front();
			n_results++;
			if (want.refused)
				n_refused++;
			if (want.deliver_len != 0)
				n_delivered++;
			if (want.fin_received)
				n_fin++;
			check_field("send_segment", want.send_segment, got.send_segment);
			check_field("out_flags", want.out_flags, got.out_flags);
			check_field("out_seq", want.out_seq, got.out_seq);
			check_field("out_ack", want.out_ack, got.out_ack);
			check_field("out_win", want.out_win, got.out_win);
			check_field("out_payload_len", want.out_payload_len, got.out_payload_len);
			check_field("deliver_len", want.deliver_len, got.deliver_len);
			check_field("app_unblock", want.app_unblock, got.app_unblock);
			check_field("fin_received", want.fin_received, got.fin_received);
			check_field("conn_done", want.conn_done, got.conn_done);
			check_field("refused", want.refused, got.refused);
			check_field("last_result", want.last_result, got.last_result);
		endfunction

		function int pending();
			return awaited_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [1:0]       cfg_index;
	logic [31:0]      cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       opcode;
	logic [7:0]       seg_flags;
	logic [31:0]      seg_seq;
	logic [31:0]      seg_ack;
	logic [LEN_W-1:0] seg_len;
	logic             header_ok;
	logic [LEN_W-1:0] app_len;
	logic             out_valid;
	logic             out_stall;
	logic             send_segment;
	logic [7:0]       out_flags;
	logic [31:0]      out_seq;
	logic [31:0]      out_ack;
	logic [15:0]      out_win;
	logic [LEN_W-1:0] out_payload_len;
	logic [LEN_W-1:0] deliver_len;
	logic             app_unblock;
	logic             fin_received;
	logic             conn_done;
	logic             refused;
	logic             last_result;

	conn_scoreboard sb = new();

	// Idling rates in percent, changed by the stimulus as the run moves through its stages.
	int   send_idle_pct = 19;
	int   recv_idle_pct = 80;
	// Raised by the stimulus to ask the receiver for one long hold-off; the receiver clears it.
	logic long_hold = 1'b0;
	int   items_sent = 0;

	tcp_connection_fsm_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.seg_flags       (seg_flags),
		.seg_seq         (seg_seq),
		.seg_ack         (seg_ack),
		.seg_len         (seg_len),
		.header_ok       (header_ok),
		.app_len         (app_len),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.send_segment    (send_segment),
		.out_flags       (out_flags),
		.out_seq         (out_seq),
		.out_ack         (out_ack),
		.out_win         (out_win),
		.out_payload_len (out_payload_len),
		.deliver_len     (deliver_len),
		.app_unblock     (app_unblock),
		.fin_received    (fin_received),
		.conn_done       (conn_done),
		.refused         (refused),
		.last_result     (last_result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Both channels are sampled at the rising edge, before any of this edge's nonblocking
	// updates land, so an accepted transaction is seen exactly as the block saw it.
	always @(posedge clk) begin
		item_t ev;
		res_t  got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				ev.opcode    = opcode;
				ev.seg_flags = seg_flags;
				ev.seg_seq   = seg_seq;
				ev.seg_ack   = seg_ack;
				ev.seg_len   = seg_len;
				ev.header_ok = header_ok;
				ev.app_len   = app_len;
				sb.note_event(ev);
			end
			if (out_valid && !out_stall) begin
				got.send_segment    = send_segment;
				got.out_flags       = out_flags;
				got.out_seq         = out_seq;
				got.out_ack         = out_ack;
				got.out_win         = out_win;
				got.out_payload_len = out_payload_len;
				got.deliver_len     = deliver_len;
				got.app_unblock     = app_unblock;
				got.fin_received    = fin_received;
				got.conn_done       = conn_done;
				got.refused         = refused;
				got.last_result     = last_result;
				sb.check_result(got);
			end
		end
	end

	// Receiver. Outside the long hold-off it stalls at random at the current rate. The
	// hold-off is counted here, so the sender keeps offering transactions meanwhile and the
	// result queue fills until the block stalls its input.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Offers one event and returns at the edge at which it was accepted. Valid is left high,
	// so back-to-back events keep it high without lowering it in between.
	task automatic push_event(input item_t ev);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= ev.opcode;
		seg_flags <= ev.seg_flags;
		seg_seq   <= ev.seg_seq;
		seg_ack   <= ev.seg_ack;
		seg_len   <= ev.seg_len;
		header_ok <= ev.header_ok;
		app_len   <= ev.app_len;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Stops offering events and waits until every awaited result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Register writes happen only while the block is idle; the enable is lowered in a cycle
	// of its own so that consecutive writes never drive it twice in one step.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	// Application events carry random values in the segment fields, which must be ignored.
	function automatic item_t app_item(opcode_t op, logic [LEN_W-1:0] len);
		item_t ev;
		ev.opcode    = op;
		ev.seg_flags = 8'($urandom_range(255));
		ev.seg_seq   = $urandom;
		ev.seg_ack   = $urandom;
		ev.seg_len   = LEN_W'($urandom_range(1023));
		ev.header_ok = 1'($urandom_range(1));
		ev.app_len   = len;
		return ev;
	endfunction

	function automatic item_t seg_item(logic [7:0] fl, logic [31:0] sq, logic [31:0] ak,
			logic [LEN_W-1:0] len, logic hok);
		item_t ev;
		ev.opcode    = OP_SEG;
		ev.seg_flags = fl;
		ev.seg_seq   = sq;
		ev.seg_ack   = ak;
		ev.seg_len   = len;
		ev.header_ok = hok;
		ev.app_len   = LEN_W'($urandom_range(1023));
		return ev;
	endfunction

	// Mostly legal lengths, with a share above the payload limit to exercise saturation.
	function automatic logic [LEN_W-1:0] rand_len();
		if ($urandom_range(99) < 15)
			return LEN_W'($urandom_range(1023, MAX_PAYLOAD + 1));
		return LEN_W'($urandom_range(MAX_PAYLOAD, 0));
	endfunction

	// Main stimulus. Reset is applied once, so the run carries a single connection: it is
	// opened, kept established for most of the run with random data traffic, closed or
	// aborted in one of several ways, and then fed noise that must all be refused.
	initial begin
		logic       active;
		ending_t    ending;
		int         stage;
		logic [7:0] fl;
		item_t      ev;
		active = 1'($urandom_range(1));
		ending = ending_t'($urandom_range(3));
		stage  = 0;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_ACTIVE_OPEN;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		opcode    <= OP_START;
		seg_flags <= '0;
		seg_seq   <= '0;
		seg_ack   <= '0;
		seg_len   <= '0;
		header_ok <= 1'b0;
		app_len   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_ADV_WINDOW, 32'h0000_FFFF);
		write_reg(CFG_INITIAL_SEQ, 32'hFFFF_FFFF);
		write_reg(CFG_ACTIVE_OPEN, 32'd0);

		// A start while waiting passively sends nothing and leaves the machine listening,
		// so either kind of open can still follow.
		push_event(app_item(OP_START, '0));
		if (active) begin
			drain();
			write_reg(CFG_ACTIVE_OPEN, 32'd1);
			push_event(app_item(OP_START, '0));
			push_event(seg_item(FL_SYNACK, 32'hFFFF_FFFF, $urandom, 10'h3FF, 1'b1));
		end else begin
			push_event(seg_item(F_SYN, 32'hFFFF_FFFF, 32'h0, '0, 1'b1));
			push_event(seg_item(F_ACK, $urandom, $urandom, 10'd537, 1'b1));
		end

		// Established: saturated and zero lengths, wrapping sums, and data replies whose
		// flags are not examined, including one that looks like a FIN-ACK.
		push_event(app_item(OP_DATA, 10'h3FF));
		push_event(seg_item(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd537, 1'b1));
		push_event(app_item(OP_DATA, '0));
		push_event(seg_item(8'h00, 32'h0, 32'h0, '0, 1'b1));
		push_event(seg_item(F_FIN, 32'hFFFF_FFFF, $urandom, 10'd536, 1'b1));
		push_event(seg_item(8'hEE, 32'h0, 32'hFFFF_FFFF, 10'h3FF, 1'b1));
		push_event(app_item(OP_DATA, 10'd536));
		push_event(seg_item(FL_FINACK, $urandom, $urandom, 10'd1, 1'b1));

		// Random established traffic: data sent and its reply, or data received. Received
		// segments avoid the exact FIN-ACK byte, which would start the passive close.
		while (items_sent < RANDOM_UPTO) begin
			if (stage == 0 && items_sent >= STAGE1_AT) begin
				drain();
				write_reg(CFG_ADV_WINDOW, 32'd0);
				write_reg(CFG_INITIAL_SEQ, 32'd0);
				write_reg(CFG_ACTIVE_OPEN, {31'd0, !active});
				send_idle_pct = 80;
				recv_idle_pct = 19;
				stage = 1;
			end
			if (stage == 1 && items_sent >= STAGE2_AT) begin
				drain();
				write_reg(CFG_ADV_WINDOW, $urandom_range(65535));
				write_reg(CFG_INITIAL_SEQ, $urandom);
				write_reg(CFG_ACTIVE_OPEN, $urandom_range(1));
				send_idle_pct = 0;
				recv_idle_pct = 0;
				long_hold = 1'b1;
				stage = 2;
			end
			if ($urandom_range(99) < 45) begin
				push_event(app_item(OP_DATA, rand_len()));
				push_event(seg_item(8'($urandom_range(255)), $urandom, $urandom, rand_len(),
					1'b1));
			end else begin
				fl = 8'($urandom_range(255));
				if (fl == FL_FINACK)
					fl = F_ACK;
				push_event(seg_item(fl, $urandom, $urandom, rand_len(), 1'b1));
			end
		end

		case (ending)
			END_PASSIVE: begin
				push_event(seg_item(FL_FINACK, $urandom, $urandom, rand_len(), 1'b1));
				push_event(seg_item(F_ACK, $urandom, $urandom, rand_len(), 1'b1));
			end
			END_ACTIVE: begin
				push_event(app_item(OP_CLOSE, LEN_W'($urandom_range(1023))));
				push_event(seg_item(F_ACK, $urandom, $urandom, rand_len(), 1'b1));
				push_event(seg_item(FL_FINACK, $urandom, $urandom, rand_len(), 1'b1));
			end
			END_SIMULT: begin
				push_event(app_item(OP_CLOSE, LEN_W'($urandom_range(1023))));
				push_event(seg_item(FL_FINACK, $urandom, $urandom, rand_len(), 1'b1));
				push_event(seg_item(F_ACK, $urandom, $urandom, rand_len(), 1'b1));
			end
			default: begin
				// Abort by a start while established, a truncated header, or a close
				// answered with flags that are not the ones awaited.
				case ($urandom_range(2))
					0: push_event(app_item(OP_START, rand_len()));
					1: push_event(seg_item(8'($urandom_range(255)), $urandom, $urandom,
						rand_len(), 1'b0));
					default: begin
						push_event(app_item(OP_CLOSE, rand_len()));
						push_event(seg_item(FL_SYNACK, $urandom, $urandom, rand_len(), 1'b1));
					end
				endcase
			end
		endcase

		// Once closed or refused, every event of any shape gets a refusal and nothing else.
		repeat (NOISE_ITEMS) begin
			ev.opcode    = 2'($urandom_range(3));
			ev.seg_flags = 8'($urandom_range(255));
			ev.seg_seq   = $urandom;
			ev.seg_ack   = $urandom;
			ev.seg_len   = LEN_W'($urandom_range(1023));
			ev.header_ok = 1'($urandom_range(1));
			ev.app_len   = LEN_W'($urandom_range(1023));
			push_event(ev);
		end

		drain();
		// An idle wait after the drain catches any result the block sends beyond those awaited.
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d awaited results never arrived", sb.pending());
			sb.errors++;
		end

		$display("Connection opened %s, ended by %s.", active ? "actively" : "passively",
			ending.name());
		$display("%0d events, %0d results checked: %0d refusals, %0d deliveries, %0d FINs.",
			sb.n_events, sb.n_results, sb.n_refused, sb.n_delivered, sb.n_fin);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== tcp_connection_fsm_top.f =====
+incdir+rtl
rtl/tcpfsm_pkg.sv
rtl/tcpfsm_cfg.sv
rtl/tcpfsm_core.sv
rtl/tcpfsm_outq.sv
rtl/tcp_connection_fsm_top.sv
test/tb_tcp_connection_fsm_top.sv
